[hw/rtl/spq_pkg.sv]
// spq_pkg: sizes, codes and shared types of the sorted priority queue
// no dependencies; used by every file of the block
package spq_pkg;

  localparam int QUEUE_DEPTH = 256;
  localparam int KEY_W       = 24;
  localparam int PAY_W       = 16;
  localparam int STATUS_W    = 2;
  localparam int ECOUNT_W    = 9;
  localparam int CNT_MIN_W   = $clog2(QUEUE_DEPTH + 1);
  localparam int CNT_W       = (CNT_MIN_W > ECOUNT_W) ? CNT_MIN_W : ECOUNT_W;

  typedef enum logic {
    OP_INSERT  = 1'b0,
    OP_DEQUEUE = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED = 2'd0,
    ST_DEQUEUED = 2'd1,
    ST_EMPTY    = 2'd2,
    ST_DROPPED  = 2'd3
  } status_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [PAY_W-1:0] payload;
  } entry_t;

  typedef struct packed {
    logic   ins;
    logic   deq;
    entry_t new_entry;
  } cell_ctl_t;

  typedef struct packed {
    status_t             status;
    logic [PAY_W-1:0]    out_payload;
    logic [KEY_W-1:0]    out_priority;
    logic [ECOUNT_W-1:0] entry_count;
  } result_t;

endpackage

[hw/rtl/spq_if.sv]
// spq_in_if, spq_out_if: valid/ready channels of the sorted priority queue
// depends on spq_pkg for field widths
interface spq_in_if;
  logic                     valid;
  logic                     ready;
  logic                     op;
  logic [spq_pkg::PAY_W-1:0] payload;
  logic [spq_pkg::KEY_W-1:0] priority_req;

  modport source (output valid, output op, output payload, output priority_req, input ready);
  modport sink   (input valid, input op, input payload, input priority_req, output ready);
endinterface

interface spq_out_if;
  logic                        valid;
  logic                        ready;
  logic [spq_pkg::STATUS_W-1:0] status;
  logic [spq_pkg::PAY_W-1:0]    out_payload;
  logic [spq_pkg::KEY_W-1:0]    out_priority;
  logic [spq_pkg::ECOUNT_W-1:0] entry_count;

  modport source (output valid, output status, output out_payload, output out_priority,
                  output entry_count, input ready);
  modport sink   (input valid, input status, input out_payload, input out_priority,
                  input entry_count, output ready);
endinterface

[hw/rtl/sorted_priority_queue_core.sv]
// sorted_priority_queue_core: bounded min-priority queue on a systolic row of slots
// depends on spq_pkg, spq_if and spq_chain
//
// in_ch carries one item per handshake: op (insert or dequeue), payload and
// priority_req. out_ch returns exactly one result item per input item: status,
// out_payload, out_priority and entry_count, in input order.
// Every slot compares the incoming key with its own key in parallel and then
// keeps, takes the new entry or shifts one place, so the queue accepts one
// item per cycle while in_ready is high; the compare in the slot row sets that figure.
// Each result is registered in the output buffer before it is presented.
// An insert into a full queue is dropped with status dropped; a dequeue of an
// empty queue returns status empty. Among equal keys the newest is served first.
// Reset (rst_n low, synchronous) empties the queue and the result buffer; no
// clearing pass is needed, slot contents above the count are ignored.
// Results sit in a two-entry output buffer: while out_ready is low one more
// item is accepted, then in_ready drops until a result is taken.
module sorted_priority_queue_core (
  input  logic       clk,
  input  logic       rst_n,
  spq_in_if.sink     in_ch,
  spq_out_if.source  out_ch
);

  logic [spq_pkg::CNT_W-1:0] count_r;
  logic [spq_pkg::CNT_W-1:0] count_nxt;
  spq_pkg::cell_ctl_t        ctl;
  spq_pkg::entry_t           head;
  spq_pkg::result_t          res;
  spq_pkg::result_t          a_r, a_nxt, b_r, b_nxt;
  logic                      a_v_r, a_v_nxt, b_v_r, b_v_nxt;
  logic                      accept;
  logic                      pop;
  logic                      full;
  logic                      empty;

  assign in_ch.ready = !b_v_r;
  assign accept      = in_ch.valid && in_ch.ready;
  assign pop         = a_v_r && out_ch.ready;
  assign full        = count_r == spq_pkg::CNT_W'(spq_pkg::QUEUE_DEPTH);
  assign empty       = count_r == '0;

  always_comb begin
    ctl.ins               = 1'b0;
    ctl.deq               = 1'b0;
    ctl.new_entry.key     = in_ch.priority_req;
    ctl.new_entry.payload = in_ch.payload;
    count_nxt             = count_r;
    res.status            = spq_pkg::ST_INSERTED;
    res.out_payload       = '0;
    res.out_priority      = '0;
    if (in_ch.op == spq_pkg::OP_INSERT) begin
      if (full) begin
        res.status = spq_pkg::ST_DROPPED;
      end else begin
        ctl.ins   = accept;
        count_nxt = count_r + 1'b1;
      end
    end else begin
      if (empty) begin
        res.status = spq_pkg::ST_EMPTY;
      end else begin
        ctl.deq          = accept;
        count_nxt        = count_r - 1'b1;
        res.status       = spq_pkg::ST_DEQUEUED;
        res.out_payload  = head.payload;
        res.out_priority = head.key;
      end
    end
    res.entry_count = count_nxt[spq_pkg::ECOUNT_W-1:0];
  end

  spq_chain u_chain (
    .clk   (clk),
    .ctl   (ctl),
    .count (count_r),
    .head  (head)
  );

  // two-entry result buffer
  always_comb begin
    a_nxt   = a_r;
    b_nxt   = b_r;
    a_v_nxt = a_v_r;
    b_v_nxt = b_v_r;
    if (pop && accept) begin
      a_nxt = res;
    end else if (pop) begin
      a_nxt   = b_r;
      a_v_nxt = b_v_r;
      b_v_nxt = 1'b0;
    end else if (accept) begin
      if (a_v_r) begin
        b_nxt   = res;
        b_v_nxt = 1'b1;
      end else begin
        a_nxt   = res;
        a_v_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      a_v_r   <= 1'b0;
      b_v_r   <= 1'b0;
    end else begin
      if (accept) begin
        count_r <= count_nxt;
      end
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    b_r <= b_nxt;
  end

  assign out_ch.valid        = a_v_r;
  assign out_ch.status       = a_r.status;
  assign out_ch.out_payload  = a_r.out_payload;
  assign out_ch.out_priority = a_r.out_priority;
  assign out_ch.entry_count  = a_r.entry_count;

endmodule

[hw/rtl/spq_cell.sv]
// spq_cell: one slot of the sorted queue, keeps, takes the new item or shifts
// depends on spq_pkg
module spq_cell (
  input  logic               clk,
  input  spq_pkg::cell_ctl_t ctl,
  input  logic               occ,
  input  logic               left_keep,
  input  spq_pkg::entry_t    left_entry,
  input  spq_pkg::entry_t    right_entry,
  output spq_pkg::entry_t    entry,
  output logic               keep
);

  spq_pkg::entry_t entry_r;
  spq_pkg::entry_t entry_nxt;

  assign entry = entry_r;
  assign keep  = occ && (entry_r.key < ctl.new_entry.key);

  always_comb begin
    entry_nxt = entry_r;
    if (ctl.ins && !keep) begin
      entry_nxt = left_keep ? ctl.new_entry : left_entry;
    end else if (ctl.deq) begin
      entry_nxt = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

[hw/rtl/spq_chain.sv]
// spq_chain: row of spq_cell slots in ascending key order, slot 0 is the head
// depends on spq_pkg and spq_cell
module spq_chain (
  input  logic                      clk,
  input  spq_pkg::cell_ctl_t        ctl,
  input  logic [spq_pkg::CNT_W-1:0] count,
  output spq_pkg::entry_t           head
);

  spq_pkg::entry_t entries [spq_pkg::QUEUE_DEPTH];
  logic            keeps   [spq_pkg::QUEUE_DEPTH];

  assign head = entries[0];

  for (genvar i = 0; i < spq_pkg::QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [spq_pkg::CNT_W-1:0] Idx = spq_pkg::CNT_W'(i);
    logic            occ;
    logic            left_keep;
    spq_pkg::entry_t left_entry;
    spq_pkg::entry_t right_entry;

    assign occ = Idx < count;

    if (i == 0) begin : g_first
      assign left_keep  = 1'b1;
      assign left_entry = ctl.new_entry;
    end else begin : g_mid
      assign left_keep  = keeps[i-1];
      assign left_entry = entries[i-1];
    end

    if (i == spq_pkg::QUEUE_DEPTH - 1) begin : g_last
      assign right_entry = entries[i];
    end else begin : g_inner
      assign right_entry = entries[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .occ         (occ),
      .left_keep   (left_keep),
      .left_entry  (left_entry),
      .right_entry (right_entry),
      .entry       (entries[i]),
      .keep        (keeps[i])
    );
  end

endmodule

[hw/rtl/spq_checker.sv]
// spq_checker: port-level checks of sorted_priority_queue_core, attached by bind
// depends on spq_pkg
module spq_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [spq_pkg::STATUS_W-1:0] status,
  input logic [spq_pkg::PAY_W-1:0]    out_payload,
  input logic [spq_pkg::KEY_W-1:0]    out_priority,
  input logic [spq_pkg::ECOUNT_W-1:0] entry_count
);

  localparam logic [spq_pkg::ECOUNT_W-1:0] FullCount =
    spq_pkg::ECOUNT_W'(spq_pkg::QUEUE_DEPTH);

  a_result_next: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> out_valid)
    else $error("no result after accepted item");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_no_ready_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("input blocked with no result pending");

  a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == spq_pkg::ST_EMPTY) |-> entry_count == '0)
    else $error("empty status with nonzero count");

  a_dropped_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (status == spq_pkg::ST_DROPPED)
      |-> entry_count == FullCount && out_payload == '0 && out_priority == '0)
    else $error("dropped insert with wrong count or data");

endmodule

bind sorted_priority_queue_core spq_checker u_spq_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .status       (out_ch.status),
  .out_payload  (out_ch.out_payload),
  .out_priority (out_ch.out_priority),
  .entry_count  (out_ch.entry_count)
);
